// File: hdl/pll_pkg.sv
`timescale 1ns / 1ps

package pll_pkg;

  localparam int NODE_COUNT = 64;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int LINK_W     = IDX_W + 1;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int TGT_W  = 6;
  localparam int STAT_W = 2;
  localparam int RES_W  = 6;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NODE_COUNT);

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_NODE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_TAIL  = 5'b00100,
    S_LINK2 = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

endpackage

// File: hdl/pll_ram.sv
`timescale 1ns / 1ps

module pll_ram #(
  parameter int DW = 8,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/pooled_linked_list_engine.sv
`timescale 1ns / 1ps

// Linked list of 32-bit words in a pool of 64 nodes, with free nodes on a
// stack. Raise start with a request while busy is low; each request gives one
// result, shown for exactly one cycle with out_valid high, and the receiver
// cannot hold it off. Error results and unused command codes answer on the
// next cycle without raising busy. Prepend passes through the pop state only
// and insert-after through pop and the second link write. Append into an
// empty list passes through pop only, otherwise through pop and then a walk
// of the links to the tail (up to 64 links); search and delete walk from the
// head through the nodes (up to 64). The single read port of the link memory,
// followed one link per cycle, paces these walks. No clearing pass is needed
// after reset. The result is shown in the first cycle with busy low again.
module pooled_linked_list_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [pll_pkg::CMD_W-1:0] in_command,
  input  logic [pll_pkg::VAL_W-1:0] in_value,
  input  logic [pll_pkg::TGT_W-1:0] in_target_node,
  output logic                       out_valid,
  output logic [pll_pkg::STAT_W-1:0] out_status,
  output logic [pll_pkg::RES_W-1:0]  out_result_node,
  output logic                       out_result_node_valid
);

  pll_pkg::state_t state_r, state_nxt;

  pll_pkg::idx_t  head_r, head_nxt;
  logic           list_ne_r, list_ne_nxt;
  pll_pkg::idx_t  ftop_r, ftop_nxt;
  logic           free_ne_r, free_ne_nxt;
  logic [pll_pkg::NODE_COUNT-1:0] in_use_r, in_use_nxt;
  logic [pll_pkg::NODE_COUNT-1:0] fl_wr_r, fl_wr_nxt;

  logic [pll_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [pll_pkg::VAL_W-1:0] val_r, val_nxt;
  pll_pkg::idx_t  tgt_r, tgt_nxt;
  pll_pkg::idx_t  cur_r, cur_nxt;
  pll_pkg::idx_t  prev_r, prev_nxt;
  logic           have_prev_r, have_prev_nxt;
  pll_pkg::idx_t  new_r, new_nxt;
  pll_pkg::link_t steps_r, steps_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [pll_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [pll_pkg::RES_W-1:0]  out_node_r, out_node_nxt;
  logic                       out_node_valid_r, out_node_valid_nxt;

  pll_pkg::idx_t             rd_addr;
  pll_pkg::link_t            link_q;
  pll_pkg::link_t            fl_q;
  logic [pll_pkg::VAL_W-1:0] val_q;

  logic                      link_we;
  pll_pkg::idx_t             link_waddr;
  pll_pkg::link_t            link_wdata;
  logic                      val_we;
  logic [pll_pkg::VAL_W-1:0] val_wdata;
  logic                      fl_we;
  pll_pkg::link_t            fl_wdata;

  pll_pkg::link_t fl_eff;
  logic           link_end;
  pll_pkg::idx_t  link_idx;
  pll_pkg::idx_t  in_tgt;

  pll_ram #(.DW(pll_pkg::LINK_W), .AW(pll_pkg::IDX_W)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  pll_ram #(.DW(pll_pkg::VAL_W), .AW(pll_pkg::IDX_W)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (ftop_r),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  pll_ram #(.DW(pll_pkg::LINK_W), .AW(pll_pkg::IDX_W)) u_free_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (cur_r),
    .wdata (fl_wdata),
    .raddr (ftop_r),
    .rdata (fl_q)
  );

  assign link_end = (link_q >= pll_pkg::LINK_END);
  assign link_idx = link_q[pll_pkg::IDX_W-1:0];
  assign in_tgt   = pll_pkg::IDX_W'(in_target_node);

  // untouched free links keep their reset chain
  always_comb begin
    if (fl_wr_r[ftop_r]) begin
      fl_eff = fl_q;
    end else if (ftop_r == pll_pkg::IDX_W'(pll_pkg::NODE_COUNT - 1)) begin
      fl_eff = pll_pkg::LINK_END;
    end else begin
      fl_eff = pll_pkg::LINK_W'(ftop_r) + pll_pkg::LINK_W'(1);
    end
  end

  always_comb begin
    state_nxt          = state_r;
    head_nxt           = head_r;
    list_ne_nxt        = list_ne_r;
    ftop_nxt           = ftop_r;
    free_ne_nxt        = free_ne_r;
    in_use_nxt         = in_use_r;
    fl_wr_nxt          = fl_wr_r;
    cmd_nxt            = cmd_r;
    val_nxt            = val_r;
    tgt_nxt            = tgt_r;
    cur_nxt            = cur_r;
    prev_nxt           = prev_r;
    have_prev_nxt      = have_prev_r;
    new_nxt            = new_r;
    steps_nxt          = steps_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_node_nxt       = out_node_r;
    out_node_valid_nxt = out_node_valid_r;
    rd_addr            = head_r;
    link_we            = 1'b0;
    link_waddr         = cur_r;
    link_wdata         = pll_pkg::LINK_END;
    val_we             = 1'b0;
    val_wdata          = val_r;
    fl_we              = 1'b0;
    fl_wdata           = pll_pkg::LINK_END;

    case (state_r)
      pll_pkg::S_IDLE: begin
        rd_addr = (in_command == pll_pkg::CMD_INSERT) ? in_tgt : head_r;
        if (start) begin
          cmd_nxt            = in_command;
          val_nxt            = in_value;
          tgt_nxt            = in_tgt;
          cur_nxt            = head_r;
          steps_nxt          = '0;
          have_prev_nxt      = 1'b0;
          out_status_nxt     = pll_pkg::ST_OK;
          out_node_nxt       = '0;
          out_node_valid_nxt = 1'b0;
          case (in_command)
            pll_pkg::CMD_APPEND, pll_pkg::CMD_PREPEND: begin
              if (!free_ne_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pll_pkg::ST_NO_FREE;
              end else begin
                state_nxt = pll_pkg::S_POP;
              end
            end
            pll_pkg::CMD_INSERT: begin
              if (32'(in_target_node) >= pll_pkg::NODE_COUNT || !in_use_r[in_tgt]) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pll_pkg::ST_BAD_NODE;
              end else if (!free_ne_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pll_pkg::ST_NO_FREE;
              end else begin
                state_nxt = pll_pkg::S_POP;
              end
            end
            pll_pkg::CMD_SEARCH, pll_pkg::CMD_DELETE: begin
              if (!list_ne_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pll_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = pll_pkg::S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      pll_pkg::S_POP: begin
        new_nxt = ftop_r;
        if (fl_eff < pll_pkg::LINK_END) begin
          ftop_nxt = fl_eff[pll_pkg::IDX_W-1:0];
        end else begin
          ftop_nxt    = '0;
          free_ne_nxt = 1'b0;
        end
        val_we             = 1'b1;
        in_use_nxt[ftop_r] = 1'b1;
        link_we            = 1'b1;
        link_waddr         = ftop_r;
        rd_addr            = cur_r;
        case (cmd_r)
          pll_pkg::CMD_PREPEND: begin
            link_wdata         = list_ne_r ? pll_pkg::LINK_W'(head_r) : pll_pkg::LINK_END;
            head_nxt           = ftop_r;
            list_ne_nxt        = 1'b1;
            out_valid_nxt      = 1'b1;
            out_node_nxt       = pll_pkg::RES_W'(ftop_r);
            out_node_valid_nxt = 1'b1;
            state_nxt          = pll_pkg::S_IDLE;
          end
          pll_pkg::CMD_INSERT: begin
            link_wdata = link_q;
            state_nxt  = pll_pkg::S_LINK2;
          end
          default: begin
            link_wdata = pll_pkg::LINK_END;
            if (!list_ne_r) begin
              head_nxt           = ftop_r;
              list_ne_nxt        = 1'b1;
              out_valid_nxt      = 1'b1;
              out_node_nxt       = pll_pkg::RES_W'(ftop_r);
              out_node_valid_nxt = 1'b1;
              state_nxt          = pll_pkg::S_IDLE;
            end else begin
              state_nxt = pll_pkg::S_TAIL;
            end
          end
        endcase
      end

      pll_pkg::S_TAIL: begin
        if (link_end || steps_r == pll_pkg::LINK_W'(pll_pkg::NODE_COUNT)) begin
          link_we            = 1'b1;
          link_waddr         = cur_r;
          link_wdata         = pll_pkg::LINK_W'(new_r);
          out_valid_nxt      = 1'b1;
          out_node_nxt       = pll_pkg::RES_W'(new_r);
          out_node_valid_nxt = 1'b1;
          state_nxt          = pll_pkg::S_IDLE;
        end else begin
          cur_nxt   = link_idx;
          rd_addr   = link_idx;
          steps_nxt = steps_r + pll_pkg::LINK_W'(1);
        end
      end

      pll_pkg::S_LINK2: begin
        link_we            = 1'b1;
        link_waddr         = tgt_r;
        link_wdata         = pll_pkg::LINK_W'(new_r);
        out_valid_nxt      = 1'b1;
        out_node_nxt       = pll_pkg::RES_W'(new_r);
        out_node_valid_nxt = 1'b1;
        state_nxt          = pll_pkg::S_IDLE;
      end

      pll_pkg::S_SCAN: begin
        if (val_q == val_r) begin
          if (cmd_r == pll_pkg::CMD_DELETE) begin
            // unlink, then push onto the free stack
            if (!have_prev_r) begin
              if (!link_end) begin
                head_nxt = link_idx;
              end else begin
                head_nxt    = '0;
                list_ne_nxt = 1'b0;
              end
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_r;
              link_wdata = link_q;
            end
            fl_we             = 1'b1;
            fl_wdata          = free_ne_r ? pll_pkg::LINK_W'(ftop_r) : pll_pkg::LINK_END;
            fl_wr_nxt[cur_r]  = 1'b1;
            in_use_nxt[cur_r] = 1'b0;
            ftop_nxt          = cur_r;
            free_ne_nxt       = 1'b1;
          end
          out_valid_nxt      = 1'b1;
          out_node_nxt       = pll_pkg::RES_W'(cur_r);
          out_node_valid_nxt = 1'b1;
          state_nxt          = pll_pkg::S_IDLE;
        end else if (link_end ||
                     steps_r == pll_pkg::LINK_W'(pll_pkg::NODE_COUNT - 1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pll_pkg::ST_NOT_FOUND;
          state_nxt      = pll_pkg::S_IDLE;
        end else begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          cur_nxt       = link_idx;
          rd_addr       = link_idx;
          steps_nxt     = steps_r + pll_pkg::LINK_W'(1);
        end
      end

      default: begin
        state_nxt = pll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pll_pkg::S_IDLE;
      head_r      <= '0;
      list_ne_r   <= 1'b0;
      ftop_r      <= '0;
      free_ne_r   <= 1'b1;
      in_use_r    <= '0;
      fl_wr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      list_ne_r   <= list_ne_nxt;
      ftop_r      <= ftop_nxt;
      free_ne_r   <= free_ne_nxt;
      in_use_r    <= in_use_nxt;
      fl_wr_r     <= fl_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r            <= cmd_nxt;
    val_r            <= val_nxt;
    tgt_r            <= tgt_nxt;
    cur_r            <= cur_nxt;
    prev_r           <= prev_nxt;
    have_prev_r      <= have_prev_nxt;
    new_r            <= new_nxt;
    steps_r          <= steps_nxt;
    out_status_r     <= out_status_nxt;
    out_node_r       <= out_node_nxt;
    out_node_valid_r <= out_node_valid_nxt;
  end

  assign busy                  = (state_r != pll_pkg::S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_result_node       = out_node_r;
  assign out_result_node_valid = out_node_valid_r;

endmodule

// File: tb/list_reply_checker.sv
`timescale 1ns / 1ps

module list_reply_checker
  import pll_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [VAL_W-1:0]  in_value,
  input  logic [TGT_W-1:0]  in_target_node,
  input  logic              out_valid,
  input  logic [STAT_W-1:0] out_status,
  input  logic [RES_W-1:0]  out_result_node,
  input  logic              out_result_node_valid,
  output int                mismatches,
  output int                awaited,
  output int                ok_seen,
  output int                full_seen,
  output int                bad_target_seen,
  output int                miss_seen
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    idx_t              node;
    logic              node_ok;
  } list_reply_t;

  logic [VAL_W-1:0] word_at    [NODE_COUNT];
  link_t            next_at    [NODE_COUNT];
  link_t            spare_link [NODE_COUNT];
  logic             held       [NODE_COUNT];
  idx_t             first_node;
  logic             list_used;
  idx_t             spare_top;
  logic             free_any;

  list_reply_t replies_due[$];

  function automatic bit grab_node(input logic [VAL_W-1:0] w, output idx_t n);
    link_t nx;
    n = spare_top;
    if (!free_any) return 1'b0;
    nx = spare_link[n];
    if (nx < LINK_END) begin
      spare_top = nx[IDX_W-1:0];
    end else begin
      spare_top = '0;
      free_any  = 1'b0;
    end
    word_at[n] = w;
    next_at[n] = LINK_END;
    held[n]    = 1'b1;
    return 1'b1;
  endfunction

  task automatic apply_list_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] w,
                                    input idx_t tgt, output list_reply_t r);
    idx_t  n;
    idx_t  cur;
    idx_t  prev;
    link_t lk;
    bit    found;
    bit    has_prev;
    int    steps;
    r = '{status: ST_OK, node: '0, node_ok: 1'b0};
    case (cmd)
      CMD_APPEND: begin
        if (!grab_node(w, n)) begin
          r.status = ST_NO_FREE;
        end else begin
          if (!list_used) begin
            first_node = n;
            list_used  = 1'b1;
          end else begin
            cur = first_node;
            for (steps = 0; steps < NODE_COUNT && next_at[cur] < LINK_END; steps++)
              cur = next_at[cur][IDX_W-1:0];
            next_at[cur] = link_t'(n);
          end
          r.node    = n;
          r.node_ok = 1'b1;
        end
      end
      CMD_PREPEND: begin
        if (!grab_node(w, n)) begin
          r.status = ST_NO_FREE;
        end else begin
          next_at[n] = list_used ? link_t'(first_node) : LINK_END;
          first_node = n;
          list_used  = 1'b1;
          r.node     = n;
          r.node_ok  = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!held[tgt]) begin
          r.status = ST_BAD_NODE;
        end else if (!grab_node(w, n)) begin
          r.status = ST_NO_FREE;
        end else begin
          next_at[n]   = next_at[tgt];
          next_at[tgt] = link_t'(n);
          r.node       = n;
          r.node_ok    = 1'b1;
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        found    = 1'b0;
        has_prev = 1'b0;
        prev     = '0;
        cur      = '0;
        lk       = list_used ? link_t'(first_node) : LINK_END;
        for (steps = 0; steps < NODE_COUNT && lk < LINK_END && !found; steps++) begin
          cur = lk[IDX_W-1:0];
          if (word_at[cur] == w) begin
            found = 1'b1;
          end else begin
            prev     = cur;
            has_prev = 1'b1;
            lk       = next_at[cur];
          end
        end
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (cmd == CMD_DELETE) begin
            // unlink, then clear the node and push it on the free stack
            if (!has_prev) begin
              if (next_at[cur] < LINK_END) begin
                first_node = next_at[cur][IDX_W-1:0];
              end else begin
                first_node = '0;
                list_used  = 1'b0;
              end
            end else begin
              next_at[prev] = next_at[cur];
            end
            word_at[cur]    = '0;
            next_at[cur]    = LINK_END;
            held[cur]       = 1'b0;
            spare_link[cur] = free_any ? link_t'(spare_top) : LINK_END;
            spare_top       = cur;
            free_any        = 1'b1;
          end
          r.node    = cur;
          r.node_ok = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_reply(input string why, input list_reply_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected status %0d node %0d valid %0b, got status %0d node %0d valid %0b",
               $time, why, want.status, want.node, want.node_ok,
               out_status, out_result_node, out_result_node_valid);
  endtask

  always @(posedge clk) begin : watch
    list_reply_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < NODE_COUNT; i++) begin
        word_at[i]    = '0;
        next_at[i]    = LINK_END;
        held[i]       = 1'b0;
        spare_link[i] = (i + 1 < NODE_COUNT) ? link_t'(i + 1) : LINK_END;
      end
      first_node      = '0;
      list_used       = 1'b0;
      spare_top       = '0;
      free_any        = 1'b1;
      replies_due.delete();
      mismatches      = 0;
      ok_seen         = 0;
      full_seen       = 0;
      bad_target_seen = 0;
      miss_seen       = 0;
    end else begin
      if (start && !busy) begin
        apply_list_command(in_command, in_value, in_target_node, want);
        replies_due.push_back(want);
      end
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          flag_reply("reply with no request pending", '0);
        end else begin
          want = replies_due.pop_front();
          case (want.status)
            ST_OK:        ok_seen++;
            ST_NO_FREE:   full_seen++;
            ST_BAD_NODE:  bad_target_seen++;
            ST_NOT_FOUND: miss_seen++;
            default: ;
          endcase
          if (out_status !== want.status)
            flag_reply("status mismatch", want);
          else if (out_result_node !== want.node)
            flag_reply("result_node mismatch", want);
          else if (out_result_node_valid !== want.node_ok)
            flag_reply("result_node_valid mismatch", want);
        end
      end
    end
    awaited = replies_due.size();
  end

endmodule

// File: tb/pooled_linked_list_engine_tb.sv
`timescale 1ns / 1ps

module pooled_linked_list_engine_tb;
  import pll_pkg::*;

  localparam int ITEMS      = 1850;
  localparam int CALM_ITEMS = 200;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] word;
  } request_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_command;
  logic [VAL_W-1:0]  in_value;
  logic [TGT_W-1:0]  in_target_node;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [RES_W-1:0]  out_result_node;
  logic              out_result_node_valid;

  int mismatches;
  int awaited;
  int ok_seen;
  int full_seen;
  int bad_target_seen;
  int miss_seen;

  request_t         requests_in_flight[$];
  bit               live   [NODE_COUNT];
  logic [VAL_W-1:0] stored [NODE_COUNT];
  int               live_total = 0;
  int               sent = 0;
  int               rounds = 0;
  bit               idling = 1'b0;

  pooled_linked_list_engine DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_value             (in_value),
    .in_target_node       (in_target_node),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_result_node      (out_result_node),
    .out_result_node_valid(out_result_node_valid)
  );

  list_reply_checker scoreboard (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_value             (in_value),
    .in_target_node       (in_target_node),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_result_node      (out_result_node),
    .out_result_node_valid(out_result_node_valid),
    .mismatches           (mismatches),
    .awaited              (awaited),
    .ok_seen              (ok_seen),
    .full_seen            (full_seen),
    .bad_target_seen      (bad_target_seen),
    .miss_seen            (miss_seen)
  );

  always #5 clk = ~clk;

  // track which nodes hold words, to steer targets and values
  always @(posedge clk) begin : track_pool
    request_t done;
    if (rst_n) begin
      if (start && !busy)
        requests_in_flight.push_back('{cmd: in_command, word: in_value});
      if (out_valid && requests_in_flight.size() != 0) begin
        done = requests_in_flight.pop_front();
        if (out_result_node_valid) begin
          if (done.cmd == CMD_DELETE) begin
            if (live[out_result_node]) live_total--;
            live[out_result_node] = 1'b0;
          end else if (done.cmd != CMD_SEARCH) begin
            if (!live[out_result_node]) live_total++;
            live[out_result_node]   = 1'b1;
            stored[out_result_node] = done.word;
          end
        end
      end
    end
  end

  function automatic idx_t pick_live_node();
    idx_t k;
    int   i;
    k = idx_t'($urandom);
    for (i = 0; i < NODE_COUNT && !live[k]; i++) k = k + 1'b1;
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_word();
    return (live_total != 0) ? stored[pick_live_node()] : $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] fresh_word();
    return $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 7)) : $urandom;
  endfunction

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] w,
                      input idx_t tgt);
    if (idling && sent < ITEMS - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_command     <= cmd;
    in_value       <= w;
    in_target_node <= tgt;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  task automatic alloc_item();
    logic [CMD_W-1:0] cmd;
    cmd = CMD_W'($urandom_range(CMD_APPEND, CMD_INSERT));
    if (cmd == CMD_INSERT && live_total == 0) cmd = CMD_APPEND;
    send(cmd, fresh_word(), pick_live_node());
  endtask

  task automatic mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      send(CMD_SEARCH, pick_word(), idx_t'($urandom));
    else if (r < 55)
      send(CMD_DELETE, pick_word(), idx_t'($urandom));
    else if (r < 65)
      send($urandom_range(0, 1) ? CMD_SEARCH : CMD_DELETE, fresh_word(), idx_t'($urandom));
    else if (r < 85)
      alloc_item();
    else if (r < 93)
      send(CMD_INSERT, fresh_word(), idx_t'($urandom));
    else
      send(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom, idx_t'($urandom));
  endtask

  initial begin
    int c;
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_APPEND;
    in_value       = '0;
    in_target_node = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send(CMD_SEARCH, 32'h0000_0000, 6'd0);
    send(CMD_DELETE, 32'hFFFF_FFFF, 6'd63);
    send(CMD_INSERT, 32'h1111_1111, 6'd0);
    send(CMD_INSERT, 32'h2222_2222, 6'd63);
    for (c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send(CMD_W'(c), 32'hFFFF_FFFF, 6'd63);
    send(CMD_APPEND,  32'h0000_0000, 6'd0);
    send(CMD_APPEND,  32'hFFFF_FFFF, 6'd0);
    send(CMD_PREPEND, 32'h8000_0001, 6'd0);
    send(CMD_INSERT,  32'h3333_3333, 6'd63);
    send(CMD_INSERT,  32'h7FFF_FFFE, 6'd1);
    send(CMD_INSERT,  32'h0000_0001, 6'd0);
    send(CMD_SEARCH,  32'hFFFF_FFFF, 6'd0);
    send(CMD_SEARCH,  32'h0000_0000, 6'd0);
    send(CMD_SEARCH,  32'h1234_5678, 6'd0);
    send(CMD_DELETE,  32'h8000_0001, 6'd0);
    send(CMD_DELETE,  32'h7FFF_FFFE, 6'd0);
    send(CMD_DELETE,  32'h0000_0001, 6'd0);
    send(CMD_APPEND,  32'hAAAA_AAAA, 6'd0);
    send(CMD_PREPEND, 32'h5555_5555, 6'd0);
    send(CMD_DELETE,  32'hFFFF_FFFF, 6'd0);
    send(CMD_DELETE,  32'h0000_0000, 6'd0);
    send(CMD_DELETE,  32'hAAAA_AAAA, 6'd0);
    send(CMD_DELETE,  32'h5555_5555, 6'd0);

    while (sent < ITEMS) begin
      rounds++;
      idling = $urandom_range(0, 3) != 0;
      // fill the pool, wait out every reply, then push past full
      while (live_total < NODE_COUNT && sent < ITEMS) alloc_item();
      drain_replies();
      repeat (4) alloc_item();
      repeat ($urandom_range(60, 160))
        if (sent < ITEMS) mixed_item();
      // empty the list again
      while (live_total != 0 && sent < ITEMS)
        send(CMD_DELETE, pick_word(), pick_live_node());
      repeat (5) mixed_item();
    end

    drain_replies();
    repeat (80) @(negedge clk);
    $display("Ran %0d list requests in %0d fill/churn/drain rounds, directed edge cases first.",
             sent, rounds);
    $display("Replies: %0d ok, %0d pool full, %0d bad target, %0d not found.",
             ok_seen, full_seen, bad_target_seen, miss_seen);
    if (mismatches == 0 && awaited == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
